/* hdl/stc_pkg.sv */
// ----------------------------------------------------------------------------
// stc_pkg - shared types and constants
// Field widths, action codes, register indexes and reset values of the audio
// system time clock tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package stc_pkg;

  localparam int PTS_W   = 32;
  localparam int PLAY_W  = 24;
  localparam int EXT_W   = 32;
  localparam int QCNT_W  = 8;
  localparam int ACT_W   = 3;
  localparam int REP_W   = 32;
  localparam int CLK_W   = 48;
  localparam int INTP_W  = 32;
  localparam int LAT_W   = 24;
  localparam int WIN_W   = 24;
  localparam int SHIFT_W = 24;
  localparam int PHASE_W = 4;
  localparam int RUN_W   = 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [ACT_W-1:0] {
    ACT_PLAY   = 3'd0,
    ACT_STALE  = 3'd1,
    ACT_INSERT = 3'd2,
    ACT_DROP   = 3'd3,
    ACT_IDLE   = 3'd4
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EXT_SYNC  = 3'd0,
    CFG_LATENCY   = 3'd1,
    CFG_MAX_INTP  = 3'd2,
    CFG_WINDOW    = 3'd3,
    CFG_SHIFT     = 3'd4,
    CFG_INTERVAL  = 3'd5,
    CFG_RUNAWAY   = 3'd6
  } cfg_idx_t;

  localparam logic [INTP_W-1:0]  RST_MAX_INTP = 32'd90000;
  localparam logic [WIN_W-1:0]   RST_WINDOW   = 24'd3600;
  localparam logic [SHIFT_W-1:0] RST_SHIFT    = 24'd9000;
  localparam logic [PHASE_W-1:0] RST_INTERVAL = 4'd5;
  localparam logic [RUN_W-1:0]   RST_RUNAWAY  = 8'd10;

  localparam logic [RUN_W-1:0]  RUN_SAT   = 8'd255;
  localparam logic [QCNT_W-1:0] QUEUE_MIN = 8'd3;

endpackage

`default_nettype wire

/* hdl/stc_if.sv */
// ----------------------------------------------------------------------------
// stc_if - item channels of the clock tracker
// Valid/ready channels for playout events in and playout decisions out.
// ----------------------------------------------------------------------------
`default_nettype none

interface stc_in_if import stc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               mode;
  logic               stale;
  logic               has_pts;
  logic [PTS_W-1:0]   pts;
  logic [PLAY_W-1:0]  play_time;
  logic [EXT_W-1:0]   ext_stc;
  logic               spare_buffers;
  logic [QCNT_W-1:0]  queue_count;

  modport source (output valid, mode, stale, has_pts, pts, play_time, ext_stc,
                  spare_buffers, queue_count, input ready);
  modport sink   (input valid, mode, stale, has_pts, pts, play_time, ext_stc,
                  spare_buffers, queue_count, output ready);
endinterface

interface stc_out_if import stc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic              report_valid;
  logic              clock_valid;
  logic [REP_W-1:0]  clock_report;

  modport source (output valid, action, report_valid, clock_valid, clock_report,
                  input ready);
  modport sink   (input valid, action, report_valid, clock_valid, clock_report,
                  output ready);
endinterface

`default_nettype wire

/* hdl/stc_div.sv */
// ----------------------------------------------------------------------------
// stc_div - divide by a small constant
// Floor quotient and remainder of an unsigned word by DIVISOR, by a rounded-up
// reciprocal multiply that is exact over the whole input range.
// ----------------------------------------------------------------------------
`default_nettype none

module stc_div #(
  parameter int DIVISOR = 1,
  parameter int IN_W    = 26
) (
  input  logic [IN_W-1:0]                  x,
  output logic [IN_W-1:0]                  q,
  output logic [$clog2(DIVISOR+1)-1:0]     r
);

  localparam int REM_W  = $clog2(DIVISOR + 1);
  localparam int SHIFT  = IN_W + $clog2(DIVISOR);
  localparam int PROD_W = 2 * IN_W + 1;
  localparam longint unsigned RECIP_L =
    ((64'd1 << SHIFT) + longint'(DIVISOR) - 64'd1) / DIVISOR;
  localparam logic [IN_W:0]   RECIP = RECIP_L[IN_W:0];
  localparam logic [IN_W-1:0] DIV_C = IN_W'(DIVISOR);

  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] q_full;
  logic [IN_W-1:0]   back;

  assign prod   = PROD_W'(x) * PROD_W'(RECIP);
  assign q_full = prod >> SHIFT;
  assign q      = q_full[IN_W-1:0];
  assign back   = x - q * DIV_C;   // below DIVISOR
  assign r      = back[REM_W-1:0];

endmodule

`default_nettype wire

/* hdl/audio_stc_tracker_sync.sv */
// ----------------------------------------------------------------------------
// audio_stc_tracker_sync - audio system time clock tracker with external sync
// Decides per playout event whether to play, discard, pad with silence or
// drop, and keeps the audio clock that goes with the decision.
// ----------------------------------------------------------------------------
// One item in is one playout event (head packet or idle slot) and gives one
// item out. An item goes through an input register and a result register, so
// the block takes one item per clock when the output is not stalled; while a
// result waits, one more item is still held in the input register. All state
// (clock, interp time, check phase, runaway count) is updated in the single
// pass between the two registers. The clock is kept both in ticks and as
// floor quotient plus remainder by TICKS_PER_MPEG_TICK, so the report needs
// no wide divider; one reciprocal-multiply unit divides the short set/advance
// amount. Registers may be written through the cfg port at any time the block
// is idle; there is no read-back and indexes past the list are ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module audio_stc_tracker_sync import stc_pkg::*; #(
  parameter int TICKS_PER_MPEG_TICK = 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  stc_in_if.sink                in_ch,
  stc_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int T_W    = $clog2(TICKS_PER_MPEG_TICK + 1);
  localparam int SCL_W  = PTS_W + T_W;
  localparam int DIV_W  = PLAY_W + 1 + T_W;
  localparam int REM_W  = $clog2(TICKS_PER_MPEG_TICK + 1);
  localparam int CMP_W  = CLK_W + 3;
  localparam logic [SCL_W-1:0] TICK_C = SCL_W'(TICKS_PER_MPEG_TICK);
  // bias that keeps play - latency positive ahead of the divider
  localparam longint unsigned SET_BIAS_L = (64'd1 << PLAY_W) * TICKS_PER_MPEG_TICK;
  localparam logic [DIV_W-1:0] SET_BIAS  = SET_BIAS_L[DIV_W-1:0];
  localparam logic [CLK_W-1:0] Q_BIAS    = CLK_W'(64'd1 << PLAY_W);

  // configuration
  logic                ext_en_r;
  logic [LAT_W-1:0]    latency_r;
  logic [INTP_W-1:0]   max_intp_r;
  logic [WIN_W-1:0]    window_r;
  logic [SHIFT_W-1:0]  shift_r;
  logic [PHASE_W-1:0]  interval_r;
  logic [RUN_W-1:0]    runaway_lim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_en_r      <= 1'b0;
      latency_r     <= '0;
      max_intp_r    <= RST_MAX_INTP;
      window_r      <= RST_WINDOW;
      shift_r       <= RST_SHIFT;
      interval_r    <= RST_INTERVAL;
      runaway_lim_r <= RST_RUNAWAY;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_EXT_SYNC: ext_en_r      <= cfg_wdata[0];
        CFG_LATENCY:  latency_r     <= cfg_wdata[LAT_W-1:0];
        CFG_MAX_INTP: max_intp_r    <= cfg_wdata[INTP_W-1:0];
        CFG_WINDOW:   window_r      <= cfg_wdata[WIN_W-1:0];
        CFG_SHIFT:    shift_r       <= cfg_wdata[SHIFT_W-1:0];
        CFG_INTERVAL: interval_r    <= cfg_wdata[PHASE_W-1:0];
        CFG_RUNAWAY:  runaway_lim_r <= cfg_wdata[RUN_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic               in_vld_r;
  logic               mode_r;
  logic               stale_r;
  logic               has_pts_r;
  logic [PTS_W-1:0]   pts_r;
  logic [PLAY_W-1:0]  play_r;
  logic [EXT_W-1:0]   ext_r;
  logic               spare_r;
  logic [QCNT_W-1:0]  qcnt_r;

  logic out_vld_r;
  logic advance;

  assign advance     = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      mode_r    <= in_ch.mode;
      stale_r   <= in_ch.stale;
      has_pts_r <= in_ch.has_pts;
      pts_r     <= in_ch.pts;
      play_r    <= in_ch.play_time;
      ext_r     <= in_ch.ext_stc;
      spare_r   <= in_ch.spare_buffers;
      qcnt_r    <= in_ch.queue_count;
    end
  end

  // tracker state; floor_r/rem_r mirror clock_r divided by the tick ratio
  logic [CLK_W-1:0]    clock_r,   clock_nxt;
  logic [CLK_W-1:0]    floor_r,   floor_nxt;
  logic [REM_W-1:0]    rem_r,     rem_nxt;
  logic                ok_r,      ok_nxt;
  logic [INTP_W-1:0]   interp_r,  interp_nxt;
  logic [PHASE_W-1:0]  phase_r,   phase_nxt;
  logic [RUN_W-1:0]    run_r,     run_nxt;

  // clock update for a played or dropped packet
  logic [DIV_W-1:0]   set_x, adv_x, div_x, div_q;
  logic [REM_W-1:0]   div_r;
  logic [SCL_W-1:0]   pts_scaled;
  logic [CLK_W-1:0]   clock_set, clock_adv, floor_set, floor_adv;
  logic [INTP_W:0]    interp_sum;
  logic [INTP_W-1:0]  interp_sat;
  logic [CLK_W-1:0]   upd_clock, upd_floor;
  logic [REM_W-1:0]   upd_rem;
  logic               upd_ok;
  logic [INTP_W-1:0]  upd_interp;
  logic [CLK_W-1:0]   trunc_q;

  assign set_x = DIV_W'(play_r) + SET_BIAS - DIV_W'(latency_r);
  assign adv_x = DIV_W'(rem_r) + DIV_W'(play_r);
  assign div_x = has_pts_r ? set_x : adv_x;

  stc_div #(
    .DIVISOR (TICKS_PER_MPEG_TICK),
    .IN_W    (DIV_W)
  ) u_div (
    .x (div_x),
    .q (div_q),
    .r (div_r)
  );

  assign pts_scaled = SCL_W'(pts_r) * TICK_C;
  assign clock_set  = CLK_W'(pts_scaled) + CLK_W'(play_r) - CLK_W'(latency_r);
  assign floor_set  = CLK_W'(pts_r) + CLK_W'(div_q) - Q_BIAS;
  assign clock_adv  = clock_r + CLK_W'(play_r);
  assign floor_adv  = floor_r + CLK_W'(div_q);
  assign interp_sum = (INTP_W+1)'(interp_r) + (INTP_W+1)'(play_r);
  assign interp_sat = interp_sum[INTP_W] ? '1 : interp_sum[INTP_W-1:0];

  always_comb begin
    upd_clock  = clock_r;
    upd_floor  = floor_r;
    upd_rem    = rem_r;
    upd_ok     = ok_r;
    upd_interp = interp_r;
    if (has_pts_r) begin
      upd_clock  = clock_set;
      upd_floor  = floor_set;
      upd_rem    = div_r;
      upd_ok     = 1'b1;
      upd_interp = '0;
    end else if (ok_r) begin
      upd_clock  = clock_adv;
      upd_floor  = floor_adv;
      upd_rem    = div_r;
      upd_interp = interp_sat;
      upd_ok     = (interp_sat < max_intp_r);
    end
  end

  // truncation toward zero: negative clock with remainder rounds up
  assign trunc_q = upd_floor + CLK_W'(upd_clock[CLK_W-1] && (upd_rem != '0));

  // drift check against the external clock
  logic [SCL_W-1:0]         ext_scaled;
  logic signed [CMP_W-1:0]  diff, win_s;
  logic                     ahead, behind, deviant;
  logic [PHASE_W-1:0]       phase_inc;
  logic                     check;
  logic [RUN_W-1:0]         run_chk;
  logic                     over_lim, insert, drop;

  assign ext_scaled = SCL_W'(ext_r) * TICK_C;
  assign diff  = {{(CMP_W-CLK_W){clock_r[CLK_W-1]}}, clock_r} + CMP_W'(shift_r)
               - CMP_W'(ext_scaled);
  assign win_s   = CMP_W'(window_r);
  assign ahead   = diff > win_s;
  assign behind  = diff < -win_s;
  assign deviant = ahead || behind;

  assign phase_inc = phase_r + PHASE_W'(1);
  assign check     = ext_en_r && (phase_inc >= interval_r);
  assign run_chk   = !deviant ? '0 : (run_r == RUN_SAT) ? RUN_SAT : run_r + RUN_W'(1);
  assign over_lim  = check && (run_chk > runaway_lim_r);
  assign insert    = over_lim && spare_r && ahead;
  assign drop      = over_lim && !insert && (qcnt_r > QUEUE_MIN) && behind;

  // result and next state
  action_t           act_nxt;
  logic              rv_nxt, cv_nxt;
  logic [REP_W-1:0]  rep_nxt;

  always_comb begin
    clock_nxt  = clock_r;
    floor_nxt  = floor_r;
    rem_nxt    = rem_r;
    ok_nxt     = ok_r;
    interp_nxt = interp_r;
    phase_nxt  = phase_r;
    run_nxt    = run_r;
    act_nxt    = ACT_PLAY;
    rv_nxt     = 1'b1;
    cv_nxt     = 1'b0;
    rep_nxt    = '0;
    priority if (mode_r) begin
      ok_nxt  = 1'b0;
      act_nxt = ACT_IDLE;
    end else if (stale_r) begin
      act_nxt = ACT_STALE;
      rv_nxt  = 1'b0;
    end else begin
      if (ext_en_r) begin
        phase_nxt = check ? '0 : phase_inc;
      end
      if (check) begin
        run_nxt = (insert || drop) ? '0 : run_chk;
      end
      if (insert) begin
        ok_nxt  = 1'b0;
        act_nxt = ACT_INSERT;
      end else begin
        clock_nxt  = upd_clock;
        floor_nxt  = upd_floor;
        rem_nxt    = upd_rem;
        ok_nxt     = upd_ok;
        interp_nxt = upd_interp;
        if (drop) begin
          act_nxt = ACT_DROP;
          rv_nxt  = 1'b0;
        end else begin
          cv_nxt  = upd_ok;
          rep_nxt = trunc_q[REP_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_r  <= '0;
      floor_r  <= '0;
      rem_r    <= '0;
      ok_r     <= 1'b0;
      interp_r <= '0;
      phase_r  <= '0;
      run_r    <= '0;
    end else if (advance) begin
      clock_r  <= clock_nxt;
      floor_r  <= floor_nxt;
      rem_r    <= rem_nxt;
      ok_r     <= ok_nxt;
      interp_r <= interp_nxt;
      phase_r  <= phase_nxt;
      run_r    <= run_nxt;
    end
  end

  // result register
  action_t           act_r;
  logic              rv_r, cv_r;
  logic [REP_W-1:0]  rep_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      act_r <= act_nxt;
      rv_r  <= rv_nxt;
      cv_r  <= cv_nxt;
      rep_r <= rep_nxt;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.action       = act_r;
  assign out_ch.report_valid = rv_r;
  assign out_ch.clock_valid  = cv_r;
  assign out_ch.clock_report = rep_r;

endmodule

`default_nettype wire

/* hdl/stc_chk.sv */
// ----------------------------------------------------------------------------
// stc_chk - port checks for the clock tracker
// Result consistency and output handshake checks, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module stc_chk import stc_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input logic [ACT_W-1:0] action,
  input logic             report_valid,
  input logic             clock_valid,
  input logic [REP_W-1:0] clock_report
);

  // no report for stale or dropped packets
  a_no_report: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (action == ACT_STALE || action == ACT_DROP)
      |-> !report_valid && !clock_valid && clock_report == '0)
    else $error("stale/drop item carries a clock report");

  // silence always reports an invalid, zero clock
  a_silence: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (action == ACT_INSERT || action == ACT_IDLE)
      |-> report_valid && !clock_valid && clock_report == '0)
    else $error("silence item with valid clock report");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(action)
      && $stable(report_valid) && $stable(clock_valid) && $stable(clock_report))
    else $error("stalled result changed");

  // nothing comes out right after reset
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind audio_stc_tracker_sync stc_chk u_stc_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .action       (out_ch.action),
  .report_valid (out_ch.report_valid),
  .clock_valid  (out_ch.clock_valid),
  .clock_report (out_ch.clock_report)
);

`default_nettype wire

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb - self-checking bench for audio_stc_tracker_sync
// Drives playout events through the valid/ready input channel, predicts each
// decision and clock report from a cycle-free model of the tracker, and checks
// every result item in order. Runs a short directed part, then random event
// streams under several register settings with random stalls on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import stc_pkg::*;

  localparam int TPM            = 1;          // ticks per mpeg tick of the dut
  localparam int CLK_PERIOD     = 20;
  localparam int TIMEOUT_CYCLES = 1_000_000;
  localparam int HOLD_CYCLES    = 300;        // long receiver hold-off
  localparam int SETTLE_CYCLES  = 4;          // two register stages plus margin
  localparam int PHASE_ITEMS    = 310;
  localparam int PAUSE_AT       = 150;

  // one playout event, as offered on the input channel
  typedef struct packed {
    logic              mode;
    logic              stale;
    logic              has_pts;
    logic [PTS_W-1:0]  pts;
    logic [PLAY_W-1:0] play_time;
    logic [EXT_W-1:0]  ext_stc;
    logic              spare_buffers;
    logic [QCNT_W-1:0] queue_count;
  } playout_event_t;

  localparam int EV_W = $bits(playout_event_t);

  // one playout decision, as seen on the result channel
  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic             report_valid;
    logic             clock_valid;
    logic [REP_W-1:0] clock_report;
  } decision_t;

  // one full register setting
  typedef struct packed {
    logic [31:0] ext_sync;
    logic [31:0] latency;
    logic [31:0] max_interp;
    logic [31:0] window;
    logic [31:0] shift;
    logic [31:0] interval;
    logic [31:0] runaway;
  } reg_set_t;

  // where the external clock sits relative to our shifted clock
  typedef enum int {DRIFT_NONE, DRIFT_AHEAD, DRIFT_BEHIND, DRIFT_BOUND, DRIFT_WILD} drift_t;

  // --------------------------------------------------------------------------
  // Tracker model: own copy of registers and state, plus the queue of
  // decisions still owed by the dut.
  // --------------------------------------------------------------------------
  class stc_tracker_model;
    bit               sync_on;
    bit [LAT_W-1:0]   latency;
    bit [INTP_W-1:0]  max_interp;
    bit [WIN_W-1:0]   window;
    bit [SHIFT_W-1:0] shift;
    bit [PHASE_W-1:0] interval;
    bit [RUN_W-1:0]   runaway_lim;

    bit [CLK_W-1:0]   clk_ticks;
    bit               clock_ok;
    bit [INTP_W-1:0]  interp;
    bit [PHASE_W-1:0] phase;
    bit [RUN_W-1:0]   runaway;

    decision_t        owed_decisions[$];
    int               errors;

    function new();
      sync_on     = 1'b0;
      latency     = '0;
      max_interp  = RST_MAX_INTP;
      window      = RST_WINDOW;
      shift       = RST_SHIFT;
      interval    = RST_INTERVAL;
      runaway_lim = RST_RUNAWAY;
      clk_ticks   = '0;
      clock_ok    = 1'b0;
      interp      = '0;
      phase       = '0;
      runaway     = '0;
      errors      = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, bit [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_EXT_SYNC: sync_on     = val[0];
        CFG_LATENCY:  latency     = val[LAT_W-1:0];
        CFG_MAX_INTP: max_interp  = val[INTP_W-1:0];
        CFG_WINDOW:   window      = val[WIN_W-1:0];
        CFG_SHIFT:    shift       = val[SHIFT_W-1:0];
        CFG_INTERVAL: interval    = val[PHASE_W-1:0];
        CFG_RUNAWAY:  runaway_lim = val[RUN_W-1:0];
        default: ;
      endcase
    endfunction

    function longint signed_clock();
      return longint'($signed(clk_ticks));
    endfunction

    // set from pts, or interpolate a valid clock by the play time
    function void refresh_clock(bit has_pts, bit [PTS_W-1:0] pts, bit [PLAY_W-1:0] play);
      longint t;
      if (has_pts) begin
        clock_ok  = 1'b1;
        interp    = '0;
        clk_ticks = CLK_W'(longint'(pts) * TPM + longint'(play) - longint'(latency));
      end else if (clock_ok) begin
        clk_ticks = CLK_W'(signed_clock() + longint'(play));
        t = longint'(interp) + longint'(play);
        if (t > longint'(32'hFFFF_FFFF)) t = longint'(32'hFFFF_FFFF);
        interp = t[INTP_W-1:0];
        if (interp >= max_interp) clock_ok = 1'b0;
      end
    endfunction

    function void take_event(playout_event_t ev);
      decision_t d;
      longint    own;
      longint    xc;
      longint    win;
      bit        ahead;
      bit        behind;
      bit        decided;
      decided = 1'b0;
      d = '{ACT_PLAY, 1'b1, 1'b0, 32'd0};
      if (ev.mode) begin
        clock_ok = 1'b0;
        d = '{ACT_IDLE, 1'b1, 1'b0, 32'd0};
      end else if (ev.stale) begin
        d = '{ACT_STALE, 1'b0, 1'b0, 32'd0};
      end else begin
        if (sync_on) begin
          phase = phase + 1'b1;
          if (phase >= interval) begin
            own    = signed_clock() + longint'(shift);
            xc     = longint'(ev.ext_stc) * TPM;
            win    = longint'(window);
            ahead  = (own - xc) > win;
            behind = (xc - own) > win;
            phase  = '0;
            if (ahead || behind) begin
              if (runaway != RUN_SAT) runaway = runaway + 1'b1;
            end else begin
              runaway = '0;
            end
            if (runaway > runaway_lim && ev.spare_buffers && ahead) begin
              runaway  = '0;
              clock_ok = 1'b0;
              d = '{ACT_INSERT, 1'b1, 1'b0, 32'd0};
              decided = 1'b1;
            end else if (runaway > runaway_lim && ev.queue_count > QUEUE_MIN && behind) begin
              runaway = '0;
              refresh_clock(ev.has_pts, ev.pts, ev.play_time);
              d = '{ACT_DROP, 1'b0, 1'b0, 32'd0};
              decided = 1'b1;
            end
          end
        end
        if (!decided) begin
          refresh_clock(ev.has_pts, ev.pts, ev.play_time);
          d = '{ACT_PLAY, 1'b1, clock_ok, REP_W'(signed_clock() / TPM)};
        end
      end
      owed_decisions.push_back(d);
    endfunction

    function void check_decision(decision_t got);
      decision_t exp;
      if (owed_decisions.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: act=%0d rv=%0b cv=%0b rep=%h",
                   got.action, got.report_valid, got.clock_valid, got.clock_report);
        return;
      end
      exp = owed_decisions.pop_front();
      if (got.action !== exp.action || got.report_valid !== exp.report_valid ||
          got.clock_valid !== exp.clock_valid || got.clock_report !== exp.clock_report) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp act=%0d rv=%0b cv=%0b rep=%h, got act=%0d rv=%0b cv=%0b rep=%h",
                   exp.action, exp.report_valid, exp.clock_valid, exp.clock_report,
                   got.action, got.report_valid, got.clock_valid, got.clock_report);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, dut and channels
  // --------------------------------------------------------------------------
  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  stc_in_if  in_ch ();
  stc_out_if out_ch ();

  audio_stc_tracker_sync #(
    .TICKS_PER_MPEG_TICK (TPM)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  stc_tracker_model tracker;
  bit               calm;      // no idling on either side while set
  bit               hold_req;  // asks the receiver for one long hold-off
  drift_t           drift = DRIFT_NONE;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Hard stop in case the dut hangs a handshake.
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("tb: errors");
    $finish;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // External clock value placed relative to the model's shifted clock, so the
  // compare lands inside, on or beyond the window as asked.
  function automatic logic [EXT_W-1:0] ext_for(drift_t d);
    longint own;
    longint win;
    longint xc;
    own = tracker.signed_clock() + longint'(tracker.shift);
    win = longint'(tracker.window);
    case (d)
      DRIFT_NONE:   xc = own - win + longint'($urandom_range(0, 2 * win));
      DRIFT_AHEAD:  xc = own - win - 1 - longint'($urandom_range(0, 500));
      DRIFT_BEHIND: xc = own + win + 1 + longint'($urandom_range(0, 500));
      DRIFT_BOUND:  xc = $urandom_range(0, 1) ? own - win : own + win;
      default:      xc = longint'($urandom());
    endcase
    return EXT_W'(xc / TPM);
  endfunction

  function automatic playout_event_t make_packet(logic has_pts, logic [PTS_W-1:0] pts,
                                                 logic [PLAY_W-1:0] play, drift_t d,
                                                 logic spare, logic [QCNT_W-1:0] qc);
    playout_event_t ev;
    ev.mode          = 1'b0;
    ev.stale         = 1'b0;
    ev.has_pts       = has_pts;
    ev.pts           = pts;
    ev.play_time     = play;
    ev.ext_stc       = ext_for(d);
    ev.spare_buffers = spare;
    ev.queue_count   = qc;
    return ev;
  endfunction

  // Mostly well-formed packets that follow a slowly changing drift, with a
  // sprinkling of idle slots, stale packets and fully random noise.
  function automatic playout_event_t random_event();
    playout_event_t ev;
    int             r;
    drift_t         d;
    r = $urandom_range(0, 31);
    if ($urandom_range(0, 15) == 0) drift = drift_t'($urandom_range(DRIFT_NONE, DRIFT_BEHIND));
    d = ($urandom_range(0, 6) == 0) ? drift_t'($urandom_range(DRIFT_NONE, DRIFT_WILD)) : drift;
    ev = make_packet(($urandom_range(0, 3) == 0),
                     ($urandom_range(0, 7) == 0) ? $urandom()
                                                 : $urandom_range(100000, 32'h3FFF_FFFF),
                     ($urandom_range(0, 15) == 0) ? PLAY_W'($urandom())
                                                  : PLAY_W'($urandom_range(500, 4000)),
                     d,
                     ($urandom_range(0, 3) != 0),
                     ($urandom_range(0, 3) == 0) ? QCNT_W'($urandom_range(0, QUEUE_MIN))
                                                 : QCNT_W'($urandom_range(QUEUE_MIN + 1, 255)));
    if (r == 0) ev.mode = 1'b1;
    else if (r == 1) ev.stale = 1'b1;
    else if (r == 2) ev = EV_W'({$urandom(), $urandom(), $urandom(), $urandom()});
    return ev;
  endfunction

  // Offer one item, note it in the model once taken, then idle a while. With
  // settle set, valid is always dropped so nothing is offered afterwards.
  task automatic send_event(input playout_event_t ev, input bit settle);
    int gap;
    in_ch.valid         <= 1'b1;
    in_ch.mode          <= ev.mode;
    in_ch.stale         <= ev.stale;
    in_ch.has_pts       <= ev.has_pts;
    in_ch.pts           <= ev.pts;
    in_ch.play_time     <= ev.play_time;
    in_ch.ext_stc       <= ev.ext_stc;
    in_ch.spare_buffers <= ev.spare_buffers;
    in_ch.queue_count   <= ev.queue_count;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    tracker.take_event(ev);
    gap = pick_gap();
    if (settle && gap == 0) gap = 1;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    while (tracker.owed_decisions.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write per clock; enable drops after the last one.
  task automatic cfg_write(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    tracker.write_reg(idx, val);
  endtask

  task automatic program_regs(input reg_set_t s);
    cfg_write(CFG_EXT_SYNC, s.ext_sync);
    cfg_write(CFG_LATENCY,  s.latency);
    cfg_write(CFG_MAX_INTP, s.max_interp);
    cfg_write(CFG_WINDOW,   s.window);
    cfg_write(CFG_SHIFT,    s.shift);
    cfg_write(CFG_INTERVAL, s.interval);
    cfg_write(CFG_RUNAWAY,  s.runaway);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_random(input int n, input bit with_hold, input bit with_pause);
    for (int i = 0; i < n; i++) begin
      calm = (i >= 40 && i < 80);
      // receiver sits still while we keep offering: the block fills and
      // backpressures the input
      if (with_hold && i == 100) hold_req = 1'b1;
      if (with_pause && i == PAUSE_AT) wait_drained();
      send_event(random_event(), (i == n - 1) || (with_pause && i == PAUSE_AT - 1));
    end
    calm = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Receiver: checks every accepted result item, stalls at random, and serves
  // one long hold-off on request.
  // --------------------------------------------------------------------------
  initial begin
    int        stall;
    decision_t got;
    stall = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got.action       = out_ch.action;
        got.report_valid = out_ch.report_valid;
        got.clock_valid  = out_ch.clock_valid;
        got.clock_report = out_ch.clock_report;
        tracker.check_decision(got);
      end
      if (hold_req) begin
        hold_req = 1'b0;
        stall = HOLD_CYCLES;
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
        if (!calm && $urandom_range(0, 3) == 0) stall = pick_gap();
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  // directed sync setting: one check per packet, act on the first deviation
  localparam reg_set_t SYNC_DIRECTED = '{1, 0, 90000, 100, 0, 1, 0};

  // random phases; second and third hold the register extremes
  localparam reg_set_t PHASE_REGS [6] = '{
    '{1, 500,        90000,         3600,       9000,       1,  2},
    '{1, 24'hFF_FFFF, 0,            0,          24'hFF_FFFF, 15, 254},
    '{1, 0,          32'hFFFF_FFFF, 24'hFF_FFFF, 0,          0,  255},
    '{1, 1234,       50000,         2000,       4500,       3,  1},
    '{0, 300,        20000,         3600,       9000,       2,  5},
    '{1, 0,          90000,         50,         9000,       2,  0}
  };

  initial begin
    playout_event_t ev;
    in_ch.valid         <= 1'b0;
    in_ch.mode          <= 1'b0;
    in_ch.stale         <= 1'b0;
    in_ch.has_pts       <= 1'b0;
    in_ch.pts           <= '0;
    in_ch.play_time     <= '0;
    in_ch.ext_stc       <= '0;
    in_ch.spare_buffers <= 1'b0;
    in_ch.queue_count   <= '0;
    cfg_we              <= 1'b0;
    cfg_idx             <= CFG_EXT_SYNC;
    cfg_wdata           <= '0;
    rst_n               <= 1'b0;
    calm     = 1'b0;
    hold_req = 1'b0;
    tracker  = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed, reset register values (sync off) ---
    // interpolate with no valid clock yet
    send_event(make_packet(1'b0, 32'd0, 24'd1000, DRIFT_WILD, 1'b1, 8'd5), 1'b0);
    // smallest pts and play time
    send_event(make_packet(1'b1, 32'd0, 24'd0, DRIFT_WILD, 1'b1, 8'd5), 1'b0);
    send_event(make_packet(1'b0, 32'd0, 24'd0, DRIFT_WILD, 1'b1, 8'd5), 1'b0);
    // one huge play time runs past the interpolation limit
    send_event(make_packet(1'b0, 32'd0, 24'hFF_FFFF, DRIFT_WILD, 1'b0, 8'd0), 1'b0);
    // largest pts and play time, report keeps the low 32 bits
    send_event(make_packet(1'b1, 32'hFFFF_FFFF, 24'hFF_FFFF, DRIFT_WILD, 1'b1, 8'd255), 1'b0);
    send_event(make_packet(1'b0, 32'd0, 24'd500, DRIFT_WILD, 1'b1, 8'd4), 1'b0);
    // stale packet leaves the state alone
    ev = make_packet(1'b1, 32'd777, 24'd100, DRIFT_WILD, 1'b1, 8'd9);
    ev.stale = 1'b1;
    send_event(ev, 1'b0);
    // idle slot with every other field set: all ignored, clock goes invalid
    ev = '1;
    send_event(ev, 1'b0);
    send_event(make_packet(1'b0, 32'd0, 24'd800, DRIFT_WILD, 1'b1, 8'd4), 1'b0);
    send_event(make_packet(1'b1, 32'd12345, 24'd3000, DRIFT_WILD, 1'b0, 8'd0), 1'b0);
    send_event(make_packet(1'b0, 32'd0, 24'd3000, DRIFT_WILD, 1'b1, 8'd255), 1'b1);

    // --- directed, external sync with immediate correction ---
    wait_drained();
    program_regs(SYNC_DIRECTED);
    send_event(make_packet(1'b1, 32'd200000, 24'd1000, DRIFT_NONE, 1'b1, 8'd8), 1'b0);
    // own clock ahead with a spare buffer: silence inserted
    send_event(make_packet(1'b1, 32'd200000, 24'd1000, DRIFT_AHEAD, 1'b1, 8'd8), 1'b0);
    // ahead but no spare buffer: plays, deviation count kept
    send_event(make_packet(1'b1, 32'd210000, 24'd1000, DRIFT_AHEAD, 1'b0, 8'd2), 1'b0);
    // behind with a full enough queue: packet dropped, clock still updated
    send_event(make_packet(1'b1, 32'd220000, 24'd1000, DRIFT_BEHIND, 1'b1, 8'd4), 1'b0);
    // behind but queue at the minimum: plays
    send_event(make_packet(1'b0, 32'd0, 24'd1000, DRIFT_BEHIND, 1'b1, 8'd3), 1'b0);
    // exactly on the window edge counts as in sync
    send_event(make_packet(1'b0, 32'd0, 24'd1000, DRIFT_BOUND, 1'b1, 8'd9), 1'b0);
    send_event(make_packet(1'b0, 32'd0, 24'd1000, DRIFT_WILD, 1'b1, 8'd9), 1'b0);
    ev = make_packet(1'b0, 32'd0, 24'd1000, DRIFT_AHEAD, 1'b1, 8'd9);
    ev.mode = 1'b1;
    send_event(ev, 1'b0);
    ev.mode  = 1'b0;
    ev.stale = 1'b1;
    send_event(ev, 1'b1);

    // --- random phases ---
    for (int p = 0; p < 6; p++) begin
      wait_drained();
      program_regs(PHASE_REGS[p]);
      run_random(PHASE_ITEMS, (p == 0), (p == 1));
    end

    wait_drained();
    if (tracker.errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
hdl/stc_pkg.sv
hdl/stc_if.sv
hdl/stc_div.sv
hdl/audio_stc_tracker_sync.sv
hdl/stc_chk.sv
tb/tb.sv
